// ===== src/ffd_pkg.sv =====
package ffd_pkg;

  localparam int BYTE_W     = 8;
  localparam int INDEX_W    = 5;
  localparam int WORD_W     = 32;
  localparam int MARKER_LEN = 4;

  localparam logic [BYTE_W-1:0] MARKER [MARKER_LEN] = '{8'h00, 8'h00, 8'h80, 8'h7f};

  typedef struct packed {
    logic take_byte;
    logic load_out;
  } ffd_cmd_t;

  typedef struct packed {
    logic frame_end;
    logic last_idx;
    logic out_free;
  } ffd_status_t;

endpackage

// ===== src/ffd_if.sv =====
interface ffd_in_if import ffd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ffd_out_if import ffd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] word_index;
  logic [WORD_W-1:0]  word_value;
  logic               last_word;

  modport source (output valid, output word_index, output word_value, output last_word,
                  input ready);
  modport sink   (input valid, input word_index, input word_value, input last_word,
                  output ready);
endinterface

// ===== src/ffd_ctrl.sv =====
module ffd_ctrl import ffd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  ffd_status_t status,
  output ffd_cmd_t    cmd
);

  typedef enum logic {
    S_RX,
    S_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd           = '0;
    cmd.take_byte = (state_r == S_RX) && in_valid;
    cmd.load_out  = (state_r == S_EMIT) && status.out_free;
    in_ready      = (state_r == S_RX);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_RX: begin
        if (cmd.take_byte && status.frame_end) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (cmd.load_out && status.last_idx) begin
          state_nxt = S_RX;
        end
      end
      default: state_nxt = S_RX;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RX;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/ffd_datapath.sv =====
module ffd_datapath import ffd_pkg::*; #(
  parameter int WORD_COUNT   = 18,
  parameter int FRAME_LENGTH = 80
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ffd_cmd_t           cmd,
  output ffd_status_t        status,
  input  logic [BYTE_W-1:0]  rx_byte,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [INDEX_W-1:0] out_word_index,
  output logic [WORD_W-1:0]  out_word_value,
  output logic               out_last_word
);

  localparam int POS_W      = $clog2(FRAME_LENGTH);
  localparam int IDX_W      = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int BYTE_COUNT = WORD_COUNT * 4;
  localparam int CMP_W      = $clog2(BYTE_COUNT + FRAME_LENGTH + 1);

  localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_LENGTH - 1);
  localparam logic [POS_W-1:0] POS_HDR   = POS_W'(MARKER_LEN);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(WORD_COUNT - 1);

  logic [POS_W-1:0]  pos_r;
  logic [POS_W-1:0]  pos_nxt;
  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  idx_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [IDX_W-1:0]  word_idx_r;
  logic [WORD_W-1:0] word_value_r;
  logic              last_r;
  logic [WORD_W-1:0] store_r [WORD_COUNT];

  logic [POS_W-1:0]  k;
  logic              hunting;
  logic              store_en;
  logic [IDX_W-1:0]  waddr;

  assign hunting  = (pos_r < POS_HDR);
  assign k        = pos_r - POS_HDR;
  assign store_en = cmd.take_byte && !hunting && (CMP_W'(k) < CMP_W'(BYTE_COUNT));
  assign waddr    = IDX_W'(k >> 2);

  always_comb begin
    status           = '0;
    status.frame_end = !hunting && (pos_r == POS_LAST);
    status.last_idx  = (idx_r == IDX_LAST);
    status.out_free  = !out_valid_r || out_ready;
  end

  always_comb begin
    pos_nxt = pos_r;
    if (cmd.take_byte) begin
      if (hunting) begin
        if (rx_byte == MARKER[pos_r[1:0]]) begin
          pos_nxt = pos_r + POS_W'(1);
        end else begin
          pos_nxt = (rx_byte == MARKER[0]) ? POS_W'(1) : '0;
        end
      end else if (pos_r == POS_LAST) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.load_out) begin
      idx_nxt = status.last_idx ? '0 : idx_r + IDX_W'(1);
    end
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store_en) begin
      store_r[waddr][{k[1:0], 3'b000} +: BYTE_W] <= rx_byte;
    end
    if (cmd.load_out) begin
      word_idx_r   <= idx_r;
      word_value_r <= store_r[idx_r];
      last_r       <= status.last_idx;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_word_index = INDEX_W'(word_idx_r);
  assign out_word_value = word_value_r;
  assign out_last_word  = last_r;

`ifndef NO_ASSERTIONS
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_LAST)
    else $error("frame position out of range");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= IDX_LAST)
    else $error("word index out of range");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> (last_r == (word_idx_r == IDX_LAST)))
    else $error("last word flag does not match index");

  a_no_byte_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take_byte && status.frame_end) |=> !cmd.take_byte)
    else $error("byte taken during word burst");
`endif

endmodule

// ===== src/float_frame_deframer.sv =====
// the final byte of a frame moves the controller to S_EMIT, which loads words for output
// throughput: one byte per cycle while receiving; at frame end WORD_COUNT words are sent,
//   one per cycle the output is free, and the input stalls for that burst
// reset: synchronous, active low; clears the frame position, burst counter and output valid
// the word store is not cleared and is only read after being written
module float_frame_deframer import ffd_pkg::*; #(
  parameter int WORD_COUNT   = 18,
  parameter int FRAME_LENGTH = 80
) (
  input  logic clk,
  input  logic rst_n,
  ffd_in_if.sink    in_ch,
  ffd_out_if.source out_ch
);

  ffd_cmd_t    cmd;
  ffd_status_t status;

  ffd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  ffd_datapath #(
    .WORD_COUNT   (WORD_COUNT),
    .FRAME_LENGTH (FRAME_LENGTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .rx_byte        (in_ch.rx_byte),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_word_index (out_ch.word_index),
    .out_word_value (out_ch.word_value),
    .out_last_word  (out_ch.last_word)
  );

endmodule
